/* rtl/core/dsse_pkg.sv */
// shared types, constants and the segment lookup of the decimal seven-segment encoder
`timescale 1ns / 1ps

package dsse_pkg;

   // field widths
   localparam int VALUE_W     = 20;
   localparam int DIGIT_W     = 4;
   localparam int POSITIONS   = 6;
   localparam int DIGITS_W    = DIGIT_W * POSITIONS;
   localparam int SEG_W       = 8;
   localparam int LOW_PAT_W   = 32;
   localparam int HIGH_PAT_W  = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = LOW_PAT_W + HIGH_PAT_W;

   // configuration port
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;
   localparam int SEG_LOW_W   = 64;
   localparam int SEG_HIGH_W  = 16;
   localparam logic [SEG_LOW_W-1:0]  SEG_LOW_RESET  = 64'h7802_1219_3024_7940;
   localparam logic [SEG_HIGH_W-1:0] SEG_HIGH_RESET = 16'h1000;

   // shown positions, default
   localparam int DIGIT_COUNT = 6;

   // divide by ten: q = (v * RECIP) >> RECIP_SHIFT, exact for every 20-bit v
   localparam int RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP = 23'd6710887;
   localparam int RECIP_SHIFT = 26;
   localparam int PROD_W      = VALUE_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   typedef enum logic {
      REG_SEG_LOW  = 1'b0,
      REG_SEG_HIGH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [SEG_HIGH_W-1:0] high;
      logic [SEG_LOW_W-1:0]  low;
   } seg_table_type;

   // item moving through the digit stages: remaining value and digits found so far
   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [DIGITS_W-1:0] digits;
   } conv_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d,
                                                input seg_table_type tbl);
      logic [SEG_W-1:0] pat;
      pat = '0;
      case (d)
         4'd0:    pat = tbl.low[7:0];
         4'd1:    pat = tbl.low[15:8];
         4'd2:    pat = tbl.low[23:16];
         4'd3:    pat = tbl.low[31:24];
         4'd4:    pat = tbl.low[39:32];
         4'd5:    pat = tbl.low[47:40];
         4'd6:    pat = tbl.low[55:48];
         4'd7:    pat = tbl.low[63:56];
         4'd8:    pat = tbl.high[7:0];
         4'd9:    pat = tbl.high[15:8];
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/core/decimal_seven_segment_encoder_top.sv */
// top level of the decimal seven-segment encoder: digit pipeline, lookup and registers
`timescale 1ns / 1ps
// pipeline: from req accept to rsp_tvalid, two registers per digit for six digits,
//    then the registered segment lookup
// throughput: one item per cycle if unstalled, set by six digit stages each taking a new item
//    every cycle; every register stage moves on its own, so bubbles close up under stall
// reset: synchronous, active high; clears all valid bits and loads the default
//    active-low segment table into both pattern registers

module decimal_seven_segment_encoder_top #(
   parameter int DIGIT_COUNT = dsse_pkg::DIGIT_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dsse_pkg::REQ_DATA_W-1:0]     req_tdata,   // [19:0] binary_value, [23:20] zero
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dsse_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [31:0] low_digit_patterns,
                                                            // [47:32] high_digit_patterns
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dsse_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dsse_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dsse_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // pattern table; the user must write it only while the pipeline is empty, the block does not enforce it
   dsse_pkg::seg_table_type seg_table;

   // handshake between digit stages; index 0 is the input side
   logic               conv_vld [dsse_pkg::POSITIONS+1];
   logic               conv_rdy [dsse_pkg::POSITIONS+1];
   dsse_pkg::conv_type conv_data[dsse_pkg::POSITIONS+1];

   dsse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seg_table   (seg_table)
   );

   // item enters with no digits found yet
   assign conv_vld[0]         = req_tvalid;
   assign conv_data[0].value  = req_tdata[dsse_pkg::VALUE_W-1:0];
   assign conv_data[0].digits = '0;
   assign req_tready          = conv_rdy[0];

   // units digit first; whatever is left after the last stage (millions) is dropped
   for (genvar g = 0; g < dsse_pkg::POSITIONS; g++) begin : g_digit
      dsse_digit_stage #(
         .DIGIT_POS (g)
      ) u_digit (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (conv_vld[g]),
         .in_ready  (conv_rdy[g]),
         .in_data   (conv_data[g]),
         .out_valid (conv_vld[g+1]),
         .out_ready (conv_rdy[g+1]),
         .out_data  (conv_data[g+1])
      );
   end

   dsse_seg_map #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_seg_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_vld[dsse_pkg::POSITIONS]),
      .in_ready  (conv_rdy[dsse_pkg::POSITIONS]),
      .in_digits (conv_data[dsse_pkg::POSITIONS].digits),
      .seg_table (seg_table),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // every digit leaving the last stage is a decimal digit
   for (genvar g = 0; g < dsse_pkg::POSITIONS; g++) begin : g_chk
      a_digit_range: assert property (@(posedge clock) disable iff (reset)
         conv_vld[dsse_pkg::POSITIONS] |->
            conv_data[dsse_pkg::POSITIONS].digits[g*dsse_pkg::DIGIT_W +: dsse_pkg::DIGIT_W]
               < 4'd10)
         else $error("digit out of decimal range");
   end

   // a stalled result item stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result item changed");

   // the high pattern register keeps only its low 16 bits
   a_high_masked: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[3]) |=>
         seg_table.high == $past(csr_pwdata[dsse_pkg::SEG_HIGH_W-1:0]))
      else $error("segment table high write mismatch");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

/* rtl/core/dsse_csr.sv */
// apb-style register file holding the segment pattern table
`timescale 1ns / 1ps

module dsse_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dsse_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dsse_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dsse_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output dsse_pkg::seg_table_type             seg_table
);

   logic [dsse_pkg::SEG_LOW_W-1:0]  seg_low_ff, seg_low_in;
   logic [dsse_pkg::SEG_HIGH_W-1:0] seg_high_ff, seg_high_in;
   logic                            wr_en;
   dsse_pkg::reg_index_type         reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = dsse_pkg::reg_index_type'(csr_paddr[3]);
   assign csr_pready = 1'b1;

   always_comb begin
      seg_low_in  = seg_low_ff;
      seg_high_in = seg_high_ff;
      csr_prdata  = '0;
      unique case (reg_idx)
         dsse_pkg::REG_SEG_LOW: begin
            csr_prdata = seg_low_ff;
            if (wr_en) begin
               seg_low_in = csr_pwdata;
            end
         end
         dsse_pkg::REG_SEG_HIGH: begin
            csr_prdata = {{(dsse_pkg::CSR_DATA_W-dsse_pkg::SEG_HIGH_W){1'b0}}, seg_high_ff};
            if (wr_en) begin
               seg_high_in = csr_pwdata[dsse_pkg::SEG_HIGH_W-1:0];
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_low_ff  <= dsse_pkg::SEG_LOW_RESET;
         seg_high_ff <= dsse_pkg::SEG_HIGH_RESET;
      end else begin
         seg_low_ff  <= seg_low_in;
         seg_high_ff <= seg_high_in;
      end
   end

   assign seg_table.low  = seg_low_ff;
   assign seg_table.high = seg_high_ff;

endmodule

/* rtl/core/dsse_digit_stage.sv */
// two-register pipeline step that peels one decimal digit off the value
`timescale 1ns / 1ps

module dsse_digit_stage #(
   parameter int DIGIT_POS = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dsse_pkg::conv_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output dsse_pkg::conv_type  out_data
);

   // first register: reciprocal product
   logic                            vld_a_ff, vld_a_in;
   logic [dsse_pkg::PROD_W-1:0]     prod_ff, prod_in;
   dsse_pkg::conv_type              conv_a_ff, conv_a_in;
   logic                            rdy_a;

   // second register: quotient and digit
   logic                            vld_b_ff, vld_b_in;
   dsse_pkg::conv_type              conv_b_ff, conv_b_in;
   logic                            rdy_b;

   logic [dsse_pkg::QUOT_W-1:0]     quot;
   logic [dsse_pkg::DIGIT_W-1:0]    digit;

   assign rdy_b    = ~vld_b_ff | out_ready;
   assign rdy_a    = ~vld_a_ff | rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      vld_a_in  = rdy_a ? in_valid : vld_a_ff;
      prod_in   = prod_ff;
      conv_a_in = conv_a_ff;
      if (rdy_a) begin
         prod_in   = dsse_pkg::PROD_W'(in_data.value) * dsse_pkg::PROD_W'(dsse_pkg::RECIP);
         conv_a_in = in_data;
      end
   end

   // v - 10*q lies in 0..9, so four low bits carry it exactly
   assign quot  = prod_ff[dsse_pkg::PROD_W-1:dsse_pkg::RECIP_SHIFT];
   assign digit = conv_a_ff.value[dsse_pkg::DIGIT_W-1:0]
                - dsse_pkg::DIGIT_W'(quot[dsse_pkg::DIGIT_W-1:0] * 4'd10);

   always_comb begin
      vld_b_in  = rdy_b ? vld_a_ff : vld_b_ff;
      conv_b_in = conv_b_ff;
      if (rdy_b) begin
         conv_b_in       = conv_a_ff;
         conv_b_in.value = dsse_pkg::VALUE_W'(quot);
         conv_b_in.digits[DIGIT_POS*dsse_pkg::DIGIT_W +: dsse_pkg::DIGIT_W] = digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
         vld_b_ff <= vld_b_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      conv_a_ff <= conv_a_in;
      conv_b_ff <= conv_b_in;
   end

   assign out_valid = vld_b_ff;
   assign out_data  = conv_b_ff;

endmodule

/* rtl/core/dsse_seg_map.sv */
// segment lookup of the shown digits into the registered result
`timescale 1ns / 1ps

module dsse_seg_map #(
   parameter int DIGIT_COUNT = dsse_pkg::DIGIT_COUNT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [dsse_pkg::DIGITS_W-1:0]          in_digits,
   input  dsse_pkg::seg_table_type                seg_table,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [dsse_pkg::RSP_DATA_W-1:0]        out_data
);

   logic                                 vld_ff, vld_in;
   logic [dsse_pkg::RSP_DATA_W-1:0]      data_ff, data_in;
   logic [dsse_pkg::RSP_DATA_W-1:0]      pats;

   // one byte per position, zero where the position is not shown
   for (genvar g = 0; g < dsse_pkg::POSITIONS; g++) begin : g_pos
      if (g < DIGIT_COUNT) begin : g_shown
         assign pats[g*dsse_pkg::SEG_W +: dsse_pkg::SEG_W] =
            dsse_pkg::seg_of(in_digits[g*dsse_pkg::DIGIT_W +: dsse_pkg::DIGIT_W], seg_table);
      end else begin : g_blank
         assign pats[g*dsse_pkg::SEG_W +: dsse_pkg::SEG_W] = '0;
      end
   end

   assign in_ready = ~vld_ff | out_ready;

   always_comb begin
      vld_in  = in_ready ? in_valid : vld_ff;
      data_in = in_ready ? pats : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

/* tb/sv/segment_encode_checker.sv */
// checker of the decimal seven-segment encoder: predicts every result item and compares it
`timescale 1ns / 1ps

module segment_encode_checker
   import dsse_pkg::*;
#(
   parameter int DIGIT_COUNT = dsse_pkg::DIGIT_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // [19:0] binary_value, [23:20] zero
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,    // [31:0] low_digit_patterns,
                                               // [47:32] high_digit_patterns
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending_results
);

   localparam int REG_STRIDE = 8;

   typedef struct packed {
      logic [HIGH_PAT_W-1:0] high_pat;
      logic [LOW_PAT_W-1:0]  low_pat;
   } segment_word_type;

   logic [SEG_LOW_W-1:0]  codes_low;
   logic [SEG_HIGH_W-1:0] codes_high;
   segment_word_type      expected_patterns[$];

   // split into six decimal digits, units first, and look up each shown one
   function automatic segment_word_type encode_digits(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [3:0]         digit;
      logic [SEG_W-1:0]   seg;
      segment_word_type   word;
      rest = value;
      word = '0;
      for (int pos = 0; pos < POSITIONS; pos++) begin
         digit = 4'(rest % 10);
         rest  = rest / 10;
         seg   = '0;
         if (pos < DIGIT_COUNT) begin
            if (digit < 8) seg = codes_low[8*digit +: 8];
            else seg = codes_high[8*(digit-8) +: 8];
         end
         if (pos < 4) word.low_pat[8*pos +: 8] = seg;
         else word.high_pat[8*(pos-4) +: 8] = seg;
      end
      return word;
   endfunction

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   always @(posedge clock) begin : watch
      segment_word_type seen;
      segment_word_type want;
      if (reset) begin
         codes_low  = SEG_LOW_RESET;
         codes_high = SEG_HIGH_RESET;
         expected_patterns.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_patterns.push_back(encode_digits(req_tdata[VALUE_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_patterns.size() == 0) begin
               $error("unexpected result item: low_digit_patterns %h high_digit_patterns %h",
                      seen.low_pat, seen.high_pat);
               fail_count++;
            end else begin
               want = expected_patterns.pop_front();
               if (seen.low_pat !== want.low_pat) begin
                  $error("low_digit_patterns: expected %h, actual %h",
                         want.low_pat, seen.low_pat);
                  fail_count++;
               end
               if (seen.high_pat !== want.high_pat) begin
                  $error("high_digit_patterns: expected %h, actual %h",
                         want.high_pat, seen.high_pat);
                  fail_count++;
               end
            end
         end
         // the user must write registers only while idle; the checker itself does not enforce it
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr % REG_STRIDE == 0) begin
            case (reg_index_type'(csr_paddr / REG_STRIDE))
               REG_SEG_LOW:  codes_low  = csr_pwdata[SEG_LOW_W-1:0];
               REG_SEG_HIGH: codes_high = csr_pwdata[SEG_HIGH_W-1:0];
               default: ;
            endcase
         end
      end
      pending_results = expected_patterns.size();
   end

endmodule

/* tb/sv/tb_decimal_seven_segment_encoder_top.sv */
// testbench top of the decimal seven-segment encoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_decimal_seven_segment_encoder_top;
   import dsse_pkg::*;

   localparam int CLK_PERIOD   = 4;
   localparam int MAX_IDLE     = 6;
   localparam int HOLD_CYCLES  = 200;     // long receiver hold, well past the pipeline depth
   localparam int DRAIN_CYCLES = 30;      // idle wait before the verdict, past the pipeline depth
   localparam int CYCLE_LIMIT  = 400000;  // safety limit, well above the slowest run
   localparam int REG_STRIDE   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [19:0] binary_value, [23:20] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [31:0] low_digit_patterns,
                                              // [47:32] high_digit_patterns
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending_results;
   int cycles = 0;

   // shared flow-control knobs: idle draws on or off, and a one-shot long hold of rsp
   logic idle_on  = 1'b1;
   logic hold_rsp = 1'b0;

   // corner values: zero, bit extremes, every digit value, carries and the million wrap
   logic [VALUE_W-1:0] corner_values [22] = '{
      20'd0, 20'd1, 20'd9, 20'd10, 20'd99, 20'd100, 20'd1234, 20'd56789,
      20'd98765, 20'd123456, 20'd654321, 20'd987654, 20'd999999, 20'd1000000,
      20'd1000001, 20'd1048575, 20'd524288, 20'h55555, 20'hAAAAA, 20'd100000,
      20'd90909, 20'd808080
   };

   decimal_seven_segment_encoder_top #(.DIGIT_COUNT(DIGIT_COUNT)) u_top (.*);

   segment_encode_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_checker (.*);

   always #(CLK_PERIOD/2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: after each accepted item draw a stall, or take a long hold when asked
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_rsp) begin
            stall_left = HOLD_CYCLES;
            hold_rsp   = 1'b0;
         end
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // mostly full range, some near the million wrap and some small numbers
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_W'($urandom_range(0, 99));
         1, 2:    return VALUE_W'($urandom_range(990000, 1048575));
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // offer one item from a falling edge, return at the falling edge after it is taken;
   // valid stays up so a back-to-back item does not drop it within the same step
   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_items(input int count);
      for (int n = 0; n < count; n++) send_value(pick_value());
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   // setup phase then access phase, then the bus is released; only called while the block is idle
   task automatic write_table_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(REG_STRIDE * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners with the reset table
      foreach (corner_values[i]) send_value(corner_values[i]);
      send_random_items(380);
      wait_drained();

      // all-zero table; high register written with junk above bit 15 that must be dropped
      write_table_reg(REG_SEG_LOW, '0);
      write_table_reg(REG_SEG_HIGH, 64'hFFFF_FFFF_FFFF_0000);
      send_random_items(300);
      wait_drained();

      // all-ones table, no idling on either side
      write_table_reg(REG_SEG_LOW, '1);
      write_table_reg(REG_SEG_HIGH, '1);
      idle_on = 1'b0;
      foreach (corner_values[i]) send_value(corner_values[i]);
      send_random_items(280);
      wait_drained();
      idle_on = 1'b1;

      // distinct bytes per digit so any swapped lookup shows
      write_table_reg(REG_SEG_LOW, 64'h8877_6655_4433_2211);
      write_table_reg(REG_SEG_HIGH, {16'h0000, $urandom, 16'hAA99});
      send_random_items(150);
      // rsp holds off while items keep coming, so the pipe fills and req stalls
      hold_rsp = 1'b1;
      send_random_items(150);
      wait_drained();

      // random tables; sender pauses mid-phase until everything is back
      write_table_reg(REG_SEG_LOW, {$urandom, $urandom});
      write_table_reg(REG_SEG_HIGH, {$urandom, $urandom});
      send_random_items(200);
      wait_drained();
      send_random_items(200);
      wait_drained();

      write_table_reg(REG_SEG_LOW, {$urandom, $urandom});
      write_table_reg(REG_SEG_HIGH, {$urandom, $urandom});
      hold_rsp = 1'b1;
      send_random_items(300);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* decimal_seven_segment_encoder_top.f */
rtl/core/dsse_pkg.sv
rtl/core/dsse_csr.sv
rtl/core/dsse_digit_stage.sv
rtl/core/dsse_seg_map.sv
rtl/core/decimal_seven_segment_encoder_top.sv
tb/sv/segment_encode_checker.sv
tb/sv/tb_decimal_seven_segment_encoder_top.sv
